// ===== rtl/core/frame_pointer_unwind_checker_core_defines.svh =====
// Assertion macros shared by the frame pointer unwind checker modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FRAME_POINTER_UNWIND_CHECKER_CORE_DEFINES_SVH
`define FRAME_POINTER_UNWIND_CHECKER_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define FPUC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FPUC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPUC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fpuc_pkg.sv =====
`timescale 1ns / 1ps

package fpuc_pkg;

    // Walk limits
    localparam int unsigned DEPTH_LIMIT  = 32;
    localparam int unsigned STACK_ALIGN  = 16;
    localparam int unsigned RECORD_BYTES = 16;

    // Result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVED_SP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_END     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PC     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_MARK  = 3'd7;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_STOP    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STOP_COMPLETE      = 3'd0,
        STOP_DEPTH_LIMIT   = 3'd1,
        STOP_MISALIGNED    = 3'd2,
        STOP_OUTSIDE_STACK = 3'd3,
        STOP_UNREADABLE    = 3'd4,
        STOP_OUTSIDE_CODE  = 3'd5,
        STOP_NONMONOTONIC  = 3'd6
    } t_stop_code;

    typedef struct packed {
        logic        func;
        logic [63:0] link_pointer;
        logic [63:0] return_address;
        logic        read_fault;
    } t_in_req;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_index;
        logic [63:0] address;
        t_stop_code  stop_code;
        logic        last;
    } t_out_req;

    typedef struct packed {
        logic [63:0] stack_start;
        logic [63:0] stack_end;
        logic [63:0] saved_sp;
        logic [63:0] code_start;
        logic [63:0] code_end;
        logic [63:0] first_fp;
        logic [63:0] first_pc;
        logic [63:0] bottom_marker;
    } t_cfg;

    // Up to two results per processed input; push1 only with push0
    typedef struct packed {
        logic     push0;
        logic     push1;
        t_out_req res0;
        t_out_req res1;
    } t_push;

    typedef struct packed {
        t_out_req res;
        logic     walk;
    } t_adv;

    function automatic t_out_req mk_frame(logic [7:0] idx, logic [63:0] addr);
        t_out_req r;
        r.kind        = KIND_FRAME;
        r.frame_index = idx;
        r.address     = addr;
        r.stop_code   = STOP_COMPLETE;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_out_req mk_request(logic [63:0] addr);
        t_out_req r;
        r.kind        = KIND_REQUEST;
        r.frame_index = 8'd0;
        r.address     = addr;
        r.stop_code   = STOP_COMPLETE;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_out_req mk_stop(t_stop_code code, logic [63:0] addr);
        t_out_req r;
        r.kind        = KIND_STOP;
        r.frame_index = 8'd0;
        r.address     = addr;
        r.stop_code   = code;
        r.last        = 1'b0;
        return r;
    endfunction

    // Frame record must sit fully inside the trusted range, above saved SP
    function automatic logic in_stack(logic [63:0] fp, t_cfg cfg);
        logic [63:0] room;
        room = cfg.stack_end - fp;
        return (fp >= cfg.saved_sp) && (cfg.stack_start < cfg.stack_end) &&
               (fp >= cfg.stack_start) && (fp <= cfg.stack_end) &&
               (room >= 64'(RECORD_BYTES));
    endfunction

    function automatic logic in_code(logic [63:0] a, t_cfg cfg);
        return (a >= cfg.code_start) && (a < cfg.code_end);
    endfunction

    // Depth check, then frame pointer checks; request the record if all pass
    function automatic t_adv advance(logic [63:0] fp, logic [7:0] depth, t_cfg cfg);
        t_adv a;
        a.walk = 1'b0;
        if (depth >= 8'(DEPTH_LIMIT)) begin
            a.res = mk_stop(STOP_DEPTH_LIMIT, 64'd0);
        end else if (fp == 64'd0) begin
            a.res = mk_stop(STOP_COMPLETE, 64'd0);
        end else if ((fp & 64'(STACK_ALIGN - 1)) != 64'd0) begin
            a.res = mk_stop(STOP_MISALIGNED, fp);
        end else if (!in_stack(fp, cfg)) begin
            a.res = mk_stop(STOP_OUTSIDE_STACK, fp);
        end else begin
            a.res  = mk_request(fp);
            a.walk = 1'b1;
        end
        return a;
    endfunction

endpackage

// ===== rtl/core/frame_pointer_unwind_checker_core.sv =====
`timescale 1ns / 1ps

// Frame pointer call chain walker. A start request (func 0) reports the
// configured program counter as frame 0 and either asks for the record at
// the first frame pointer or stops; each record request (func 1) taken while
// walking is checked and yields an optional new frame plus one read request
// or stop status. Input requests are taken one per cycle when not stalled
// into an input register; all checks are single-pass logic from there into
// a 4-entry result queue. The output side moves one result per cycle while
// not stalled, so an input that yields two results (every start, and a
// record that reports a frame) needs two output transfers: sustained rate
// is one input per cycle for single-result inputs, lower when inputs yield
// two. The input stalls while a held request waits for two free queue
// entries. Registers are written through the plain write port, index as
// listed, and the user must write them only while the block is idle; the
// block itself does not enforce this.
module frame_pointer_unwind_checker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpuc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fpuc_pkg::t_in_req               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fpuc_pkg::t_out_req              o_out
);

    fpuc_pkg::t_cfg  cfg;
    fpuc_pkg::t_push push;
    logic            room2;

    fpuc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fpuc_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_room2    (room2),
        .o_push     (push)
    );

    fpuc_result_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room2     (room2),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/fpuc_cfg_regs.sv =====
`timescale 1ns / 1ps

module fpuc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpuc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                     i_cfg_wdata,
    output fpuc_pkg::t_cfg                  o_cfg
);

    fpuc_pkg::t_cfg r_cfg;
    fpuc_pkg::t_cfg n_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                fpuc_pkg::CFG_STACK_START: n_cfg.stack_start   = i_cfg_wdata;
                fpuc_pkg::CFG_STACK_END:   n_cfg.stack_end     = i_cfg_wdata;
                fpuc_pkg::CFG_SAVED_SP:    n_cfg.saved_sp      = i_cfg_wdata;
                fpuc_pkg::CFG_CODE_START:  n_cfg.code_start    = i_cfg_wdata;
                fpuc_pkg::CFG_CODE_END:    n_cfg.code_end      = i_cfg_wdata;
                fpuc_pkg::CFG_FIRST_FP:    n_cfg.first_fp      = i_cfg_wdata;
                fpuc_pkg::CFG_FIRST_PC:    n_cfg.first_pc      = i_cfg_wdata;
                fpuc_pkg::CFG_BOTTOM_MARK: n_cfg.bottom_marker = i_cfg_wdata;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/fpuc_walker.sv =====
`timescale 1ns / 1ps
`include "frame_pointer_unwind_checker_core_defines.svh"

module fpuc_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fpuc_pkg::t_in_req i_in,
    input  fpuc_pkg::t_cfg    i_cfg,
    input  logic              i_room2,
    output fpuc_pkg::t_push   o_push
);

    // Input register
    logic              r_in_valid;
    fpuc_pkg::t_in_req r_in;

    // Walk state
    logic [63:0] r_fp;
    logic [63:0] r_last_addr;
    logic [7:0]  r_depth;
    logic        r_walking;

    logic [63:0] n_fp;
    logic [63:0] n_last_addr;
    logic [7:0]  n_depth;
    logic        n_walking;

    logic            consume;
    logic            accept;
    logic            ra_new;
    logic            ra_in_code;
    logic [7:0]      depth_mid;
    fpuc_pkg::t_adv  adv;
    fpuc_pkg::t_adv  start_adv;
    fpuc_pkg::t_out_req link_res;
    logic            link_walk;
    logic            link_follow;
    fpuc_pkg::t_push push;

    // Process the held request once the queue has room for two results
    assign consume    = r_in_valid && i_room2;
    assign o_in_stall = r_in_valid && !i_room2;
    assign accept     = i_in_valid && !o_in_stall;

    // Return address and link checks for a delivered record
    always_comb begin
        start_adv  = fpuc_pkg::advance(i_cfg.first_fp, 8'd1, i_cfg);
        ra_new     = (r_in.return_address != 64'd0) &&
                     (r_in.return_address != r_last_addr);
        ra_in_code = fpuc_pkg::in_code(r_in.return_address, i_cfg);
        depth_mid  = (ra_new && ra_in_code) ? 8'(r_depth + 8'd1) : r_depth;
        adv        = fpuc_pkg::advance(r_in.link_pointer, depth_mid, i_cfg);
        link_follow = 1'b0;
        link_walk   = 1'b0;
        if ((r_in.link_pointer == 64'd0) ||
            (r_in.link_pointer == i_cfg.bottom_marker)) begin
            link_res = fpuc_pkg::mk_stop(fpuc_pkg::STOP_COMPLETE, 64'd0);
        end else if (r_in.link_pointer <= r_fp) begin
            link_res = fpuc_pkg::mk_stop(fpuc_pkg::STOP_NONMONOTONIC, r_in.link_pointer);
        end else begin
            link_res    = adv.res;
            link_walk   = adv.walk;
            link_follow = 1'b1;
        end
    end

    // Step: results and next walk state
    always_comb begin
        n_fp        = r_fp;
        n_last_addr = r_last_addr;
        n_depth     = r_depth;
        n_walking   = r_walking;
        push        = '0;
        if (consume) begin
            if (!r_in.func) begin
                // Start: report the saved PC, then check the first frame pointer
                push.res0   = fpuc_pkg::mk_frame(8'd0, i_cfg.first_pc);
                push.res1   = start_adv.res;
                push.push0  = 1'b1;
                push.push1  = 1'b1;
                n_fp        = i_cfg.first_fp;
                n_last_addr = i_cfg.first_pc;
                n_depth     = 8'd1;
                n_walking   = start_adv.walk;
            end else if (r_walking) begin
                if (r_in.read_fault) begin
                    push.res0  = fpuc_pkg::mk_stop(fpuc_pkg::STOP_UNREADABLE, r_fp);
                    push.push0 = 1'b1;
                    n_walking  = 1'b0;
                end else if (ra_new && !ra_in_code) begin
                    push.res0  = fpuc_pkg::mk_stop(fpuc_pkg::STOP_OUTSIDE_CODE,
                                                   r_in.return_address);
                    push.push0 = 1'b1;
                    n_walking  = 1'b0;
                end else if (ra_new) begin
                    push.res0   = fpuc_pkg::mk_frame(r_depth, r_in.return_address);
                    push.res1   = link_res;
                    push.push0  = 1'b1;
                    push.push1  = 1'b1;
                    n_depth     = depth_mid;
                    n_last_addr = r_in.return_address;
                    n_walking   = link_walk;
                    if (link_follow) begin
                        n_fp = r_in.link_pointer;
                    end
                end else begin
                    push.res0  = link_res;
                    push.push0 = 1'b1;
                    n_walking  = link_walk;
                    if (link_follow) begin
                        n_fp = r_in.link_pointer;
                    end
                end
            end
            // Flag the final result of this request
            if (push.push1) begin
                push.res1.last = 1'b1;
            end else if (push.push0) begin
                push.res0.last = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fp        <= '0;
            r_last_addr <= '0;
            r_depth     <= '0;
            r_walking   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            r_fp        <= n_fp;
            r_last_addr <= n_last_addr;
            r_depth     <= n_depth;
            r_walking   <= n_walking;
        end
    end

    // Input payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
    end

    assign o_push = push;

    `FPUC_ASSERT_IMPLY(a_idle_record_silent, consume && r_in.func && !r_walking, !o_push.push0, "record while idle produced a result")
    `FPUC_ASSERT_NEXT(a_stop_ends_walk, o_push.push0 && (o_push.res0.kind == fpuc_pkg::KIND_STOP || (o_push.push1 && o_push.res1.kind == fpuc_pkg::KIND_STOP)), !r_walking, "walk still active after a stop")
    `FPUC_ASSERT_IMPLY(a_walk_depth, r_walking, r_depth < 8'(fpuc_pkg::DEPTH_LIMIT), "walking at or past depth limit")

endmodule

// ===== rtl/core/fpuc_result_fifo.sv =====
`timescale 1ns / 1ps
`include "frame_pointer_unwind_checker_core_defines.svh"

module fpuc_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpuc_pkg::t_push    i_push,
    output logic               o_room2,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fpuc_pkg::t_out_req o_out
);

    localparam int unsigned AW = fpuc_pkg::FIFO_AW;
    localparam int unsigned CW = fpuc_pkg::FIFO_CW;

    fpuc_pkg::t_out_req r_mem [fpuc_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic [AW-1:0] wr_ptr1;
    logic [CW-1:0] push_cnt;
    logic          pop;

    assign wr_ptr1  = AW'(r_wr_ptr + AW'(1));
    assign push_cnt = CW'(i_push.push0) + CW'(i_push.push1);
    assign pop      = o_out_valid && !i_out_stall;

    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd_ptr];
    assign o_room2     = (r_count <= CW'(fpuc_pkg::FIFO_DEPTH - 2));

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= AW'(r_wr_ptr + AW'(push_cnt));
            if (pop) begin
                r_rd_ptr <= AW'(r_rd_ptr + AW'(1));
            end
            r_count <= CW'(r_count + push_cnt - CW'(pop));
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    `FPUC_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(fpuc_pkg::FIFO_DEPTH), "result queue overfilled")
    `FPUC_ASSERT_IMPLY(a_push_room, i_push.push0, r_count <= CW'(fpuc_pkg::FIFO_DEPTH - 2), "push without room")
    `FPUC_ASSERT_IMPLY(a_push_order, i_push.push1, i_push.push0, "second result without first")

endmodule
